FILE: hw/rtl/line_field_cut_filter_assert.svh
// Assertion macros for the line field cut filter.
// Both sample on clk and are disabled while rst is high.
`ifndef LINE_FIELD_CUT_FILTER_ASSERT_SVH
`define LINE_FIELD_CUT_FILTER_ASSERT_SVH

// Same-cycle implication.
`define LFC_ASSERT_NOW(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lfc assertion failed");

// Next-cycle implication.
`define LFC_ASSERT_NEXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lfc assertion failed");

`endif

FILE: hw/rtl/lfc_pkg.sv
`default_nettype none

package lfc_pkg;

  localparam int CHAR_W    = 16;  // width of in_char / out_char
  localparam int CFG_IDX_W = 3;
  localparam int DCNT_W    = 3;
  localparam int DSLOTS_W  = 64;  // four packed 16-bit delimiter slots

  localparam int MAX_DELIMS_DEF = 4;
  localparam int CHAR_BITS_DEF  = 16;
  localparam int COUNT_BITS_DEF = 16;

  localparam logic [CHAR_W-1:0] NEWLINE = CHAR_W'(10);

  typedef struct packed {
    logic                field_mode;
    logic [CHAR_W-1:0]   field_number;
    logic [CHAR_W-1:0]   char_offset;
    logic [CHAR_W-1:0]   max_length;
    logic [DCNT_W-1:0]   delim_count;
    logic [DSLOTS_W-1:0] delim_chars;
  } cfg_t;

endpackage

`default_nettype wire

FILE: hw/rtl/lfc_cfg.sv
`default_nettype none

module lfc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  input  wire logic [lfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lfc_pkg::DSLOTS_W-1:0]   cfg_data,
  output lfc_pkg::cfg_t                       cfg
);

  localparam logic [lfc_pkg::CFG_IDX_W-1:0] REG_FIELD_MODE   = 3'd0;
  localparam logic [lfc_pkg::CFG_IDX_W-1:0] REG_FIELD_NUMBER = 3'd1;
  localparam logic [lfc_pkg::CFG_IDX_W-1:0] REG_CHAR_OFFSET  = 3'd2;
  localparam logic [lfc_pkg::CFG_IDX_W-1:0] REG_MAX_LENGTH   = 3'd3;
  localparam logic [lfc_pkg::CFG_IDX_W-1:0] REG_DELIM_COUNT  = 3'd4;
  localparam logic [lfc_pkg::CFG_IDX_W-1:0] REG_DELIM_CHARS  = 3'd5;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.field_mode   <= 1'b0;
      cfg.field_number <= '0;
      cfg.char_offset  <= '0;
      cfg.max_length   <= '0;
      cfg.delim_count  <= lfc_pkg::DCNT_W'(1);
      cfg.delim_chars  <= lfc_pkg::DSLOTS_W'(44);  // comma in slot 0
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_FIELD_MODE:   cfg.field_mode   <= cfg_data[0];
        REG_FIELD_NUMBER: cfg.field_number <= cfg_data[lfc_pkg::CHAR_W-1:0];
        REG_CHAR_OFFSET:  cfg.char_offset  <= cfg_data[lfc_pkg::CHAR_W-1:0];
        REG_MAX_LENGTH:   cfg.max_length   <= cfg_data[lfc_pkg::CHAR_W-1:0];
        REG_DELIM_COUNT:  cfg.delim_count  <= cfg_data[lfc_pkg::DCNT_W-1:0];
        REG_DELIM_CHARS:  cfg.delim_chars  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hw/rtl/line_field_cut_filter.sv
// An accepted input is held in the input register, its result in the output register.
// Throughput: one character or line end per cycle unless the output stalls; the
// per-line counters and the delimiter compare sit between the input register and the
// output register. Items that produce nothing still occupy a slot in the pipeline.
// Reset (rst, synchronous): counters and handshake state cleared, registers to defaults.
`default_nettype none

module line_field_cut_filter #(
  parameter int MAX_DELIMS = lfc_pkg::MAX_DELIMS_DEF,
  parameter int CHAR_BITS  = lfc_pkg::CHAR_BITS_DEF,
  parameter int COUNT_BITS = lfc_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // input stream
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [lfc_pkg::CHAR_W-1:0]     s_tdata,   // [15:0] in_char
  input  wire logic                           s_tlast,   // line_end
  // output stream
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic [lfc_pkg::CHAR_W-1:0]          m_tdata,   // [15:0] out_char
  output logic                                m_tuser,   // [0] out_is_newline
  // register writes
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lfc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lfc_pkg::DSLOTS_W-1:0]   cfg_data
);

  // compare width: holds any count and offset + length without wrap
  localparam int CW = (COUNT_BITS > lfc_pkg::CHAR_W) ? COUNT_BITS : lfc_pkg::CHAR_W + 1;

  lfc_pkg::cfg_t cfg;

  lfc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign cfg_ready = 1'b1;

  // input register
  logic                       in_valid;
  logic [lfc_pkg::CHAR_W-1:0] in_char;
  logic                       in_last;

  // output register
  logic                       out_valid;
  logic [lfc_pkg::CHAR_W-1:0] out_char;
  logic                       out_nl;

  // line state
  logic [COUNT_BITS-1:0] field_index, field_index_next;
  logic [COUNT_BITS-1:0] field_position, field_position_next;
  logic                  line_emitted, line_emitted_next;

  logic advance;
  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_char <= s_tdata;
      in_last <= s_tlast;
    end
  end

  logic [CHAR_BITS-1:0]          ch;
  logic [lfc_pkg::DCNT_W-1:0]    dcnt;
  logic                          is_delim;
  logic                          selected;
  logic                          in_window;
  logic [CW-1:0]                 pos_x;
  logic [CW-1:0]                 off_x;
  logic [CW-1:0]                 end_x;
  logic                          res_valid;
  logic [lfc_pkg::CHAR_W-1:0]    res_char;
  logic                          res_nl;

  assign ch   = in_char[CHAR_BITS-1:0];
  assign dcnt = (cfg.delim_count > lfc_pkg::DCNT_W'(MAX_DELIMS)) ?
                lfc_pkg::DCNT_W'(MAX_DELIMS) : cfg.delim_count;

  always_comb begin
    is_delim = 1'b0;
    for (int i = 0; i < MAX_DELIMS; i++) begin
      if (lfc_pkg::DCNT_W'(i) < dcnt &&
          cfg.delim_chars[lfc_pkg::CHAR_W*i +: CHAR_BITS] == ch) begin
        is_delim = 1'b1;
      end
    end
  end

  assign pos_x     = CW'(field_position);
  assign off_x     = CW'(cfg.char_offset);
  assign end_x     = CW'(cfg.char_offset) + CW'(cfg.max_length);
  assign in_window = (pos_x >= off_x) && (cfg.max_length == '0 || pos_x < end_x);
  assign selected  = !cfg.field_mode || (CW'(field_index) == CW'(cfg.field_number));

  always_comb begin
    field_index_next    = field_index;
    field_position_next = field_position;
    line_emitted_next   = line_emitted;
    res_valid           = 1'b0;
    res_char            = '0;
    res_nl              = 1'b0;
    if (in_last) begin
      field_index_next    = '0;
      field_position_next = '0;
      line_emitted_next   = 1'b0;
      if (line_emitted) begin
        res_valid = 1'b1;
        res_char  = lfc_pkg::NEWLINE;
        res_nl    = 1'b1;
      end
    end else if (cfg.field_mode && is_delim) begin
      if (field_index != '1) begin
        field_index_next = field_index + COUNT_BITS'(1);
      end
      field_position_next = '0;
    end else begin
      if (field_position != '1) begin
        field_position_next = field_position + COUNT_BITS'(1);
      end
      if (selected && in_window) begin
        line_emitted_next = 1'b1;
        res_valid         = 1'b1;
        res_char          = lfc_pkg::CHAR_W'(ch);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      field_index    <= '0;
      field_position <= '0;
      line_emitted   <= 1'b0;
      out_valid      <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid && res_valid;
      if (in_valid) begin
        field_index    <= field_index_next;
        field_position <= field_position_next;
        line_emitted   <= line_emitted_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid && res_valid) begin
      out_char <= res_char;
      out_nl   <= res_nl;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_char;
  assign m_tuser  = out_nl;

endmodule

`default_nettype wire

FILE: hw/rtl/lfc_checker.sv
`default_nettype none

`include "line_field_cut_filter_assert.svh"

module lfc_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tvalid,
  input wire logic                       s_tready,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [lfc_pkg::CHAR_W-1:0] m_tdata,
  input wire logic                       m_tuser
);

  // stalled result holds
  `LFC_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser))

  // a line-closing result always carries the newline code
  `LFC_ASSERT_NOW(a_nl_code, m_tvalid && m_tuser, m_tdata == lfc_pkg::NEWLINE)

  // a newline needs a passed character after the previous newline
  `LFC_ASSERT_NEXT(a_no_double_nl, m_tvalid && m_tready && m_tuser,
                   !(m_tvalid && m_tuser))

  // a result appearing on an empty output comes from an earlier transfer, via the input register
  `LFC_ASSERT_NOW(a_out_cause, $rose(m_tvalid), $past(s_tvalid && s_tready, 2))

endmodule

bind line_field_cut_filter lfc_checker u_lfc_checker (.*);

`default_nettype wire

FILE: tb/tb_line_field_cut_filter.sv
`default_nettype none

module tb_line_field_cut_filter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = lfc_pkg::CHAR_W;
  localparam logic [CW-1:0] CH_COMMA = 16'd44;
  localparam logic [CW-1:0] CH_COLON = 16'd58;
  localparam logic [CW-1:0] CH_SEMI  = 16'd59;
  localparam logic [CW-1:0] CH_PIPE  = 16'd124;
  localparam logic [CW-1:0] CH_SPACE = 16'd32;
  localparam logic [CW-1:0] CH_TAB   = 16'd9;
  localparam logic [CW-1:0] CNT_TOP  = 16'hFFFF;

  typedef enum logic [lfc_pkg::CFG_IDX_W-1:0] {
    REG_FIELD_MODE   = 3'd0,
    REG_FIELD_NUMBER = 3'd1,
    REG_CHAR_OFFSET  = 3'd2,
    REG_MAX_LENGTH   = 3'd3,
    REG_DELIM_COUNT  = 3'd4,
    REG_DELIM_CHARS  = 3'd5,
    REG_SPARE6       = 3'd6,
    REG_SPARE7       = 3'd7
  } cut_reg_e;

  typedef struct packed {
    logic [CW-1:0] out_char;
    logic          is_newline;
  } cut_result_t;

  logic clk;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [CW-1:0] s_tdata;
  logic s_tlast;
  logic m_tvalid;
  logic m_tready;
  logic [CW-1:0] m_tdata;
  logic m_tuser;
  logic cfg_valid;
  logic cfg_ready;
  logic [lfc_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lfc_pkg::DSLOTS_W-1:0] cfg_data;

  line_field_cut_filter dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor copy of the registers
  logic          cut_field_mode;
  logic [CW-1:0] cut_field_number;
  logic [CW-1:0] cut_char_offset;
  logic [CW-1:0] cut_max_length;
  logic [2:0]    cut_delim_count;
  logic [63:0]   cut_delims;

  // predictor copy of the per-line state
  logic [CW-1:0] line_field_idx;
  logic [CW-1:0] line_char_pos;
  logic          line_has_output;

  cut_result_t pending_out[$];

  int errors = 0;
  int items_sent = 0;
  int chars_checked = 0;
  int newlines_checked = 0;
  int reg_writes = 0;
  bit tx_gaps = 1'b0;
  bit rx_stalls = 1'b0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("line_field_cut_filter: mismatch");
    $finish;
  end

  task automatic report_mismatch(string what, logic [CW-1:0] got, logic [CW-1:0] want);
    if (errors < 40)
      $display("ERROR t=%0t %s: got %h want %h", $realtime, what, got, want);
    errors++;
  endtask

  function automatic int tx_gap();
    int r;
    if (!tx_gaps) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic int rx_hold();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 1;
    if (r < 90) return $urandom_range(2, 4);
    return $urandom_range(8, 40);
  endfunction

  function automatic void clear_line();
    line_field_idx = '0;
    line_char_pos = '0;
    line_has_output = 1'b0;
  endfunction

  // expected output of one accepted character or line end
  function automatic void predict_cut(logic [CW-1:0] ch, logic le);
    cut_result_t r;
    logic hit;
    logic sel;
    logic win;
    logic [CW:0] window_end;
    int n;
    if (le) begin
      if (line_has_output) begin
        r.out_char = lfc_pkg::NEWLINE;
        r.is_newline = 1'b1;
        pending_out.push_back(r);
      end
      clear_line();
      return;
    end
    hit = 1'b0;
    n = (cut_delim_count > 3'd4) ? 4 : int'(cut_delim_count);
    if (cut_field_mode)
      for (int i = 0; i < n; i++)
        if (cut_delims[16*i +: 16] == ch) hit = 1'b1;
    if (hit) begin
      if (line_field_idx != CNT_TOP) line_field_idx++;
      line_char_pos = '0;
      return;
    end
    sel = !cut_field_mode || (line_field_idx == cut_field_number);
    window_end = {1'b0, cut_char_offset} + {1'b0, cut_max_length};
    win = (line_char_pos >= cut_char_offset) &&
          ((cut_max_length == '0) || ({1'b0, line_char_pos} < window_end));
    if (line_char_pos != CNT_TOP) line_char_pos++;
    if (sel && win) begin
      line_has_output = 1'b1;
      r.out_char = ch;
      r.is_newline = 1'b0;
      pending_out.push_back(r);
    end
  endfunction

  task automatic send_item(logic [CW-1:0] ch, logic le);
    int gap;
    gap = tx_gap();
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = ch;
    s_tlast = le;
    do @(posedge clk); while (s_tready !== 1'b1);
    predict_cut(ch, le);
    items_sent++;
  endtask

  // stop sending and let every pending result and in-flight item drain
  task automatic wait_idle();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_out.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // noisy: fill bits above the register width with junk, which must be dropped
  task automatic write_reg(cut_reg_e idx, logic [63:0] val, bit noisy = 1'b0);
    int w;
    case (idx)
      REG_FIELD_MODE: w = 1;
      REG_DELIM_COUNT: w = 3;
      REG_FIELD_NUMBER, REG_CHAR_OFFSET, REG_MAX_LENGTH: w = 16;
      default: w = 64;
    endcase
    if (noisy && w < 64) val = val | ({$urandom, $urandom} << w);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_FIELD_MODE: cut_field_mode = val[0];
      REG_FIELD_NUMBER: cut_field_number = val[15:0];
      REG_CHAR_OFFSET: cut_char_offset = val[15:0];
      REG_MAX_LENGTH: cut_max_length = val[15:0];
      REG_DELIM_COUNT: cut_delim_count = val[2:0];
      REG_DELIM_CHARS: cut_delims = val;
      default: ;
    endcase
    reg_writes++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic write_all(logic mode, logic [CW-1:0] fnum, logic [CW-1:0] offs,
                           logic [CW-1:0] mlen, logic [2:0] dcnt, logic [63:0] dch,
                           bit noisy = 1'b0);
    write_reg(REG_FIELD_MODE, 64'(mode), noisy);
    write_reg(REG_FIELD_NUMBER, 64'(fnum), noisy);
    write_reg(REG_CHAR_OFFSET, 64'(offs), noisy);
    write_reg(REG_MAX_LENGTH, 64'(mlen), noisy);
    write_reg(REG_DELIM_COUNT, 64'(dcnt), noisy);
    write_reg(REG_DELIM_CHARS, dch, noisy);
  endtask

  // ---------------- checker ----------------
  always @(posedge clk) begin : check_out
    cut_result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (pending_out.size() == 0) begin
        report_mismatch("unexpected result", m_tdata, '0);
      end else begin
        want = pending_out.pop_front();
        if (m_tdata !== want.out_char) report_mismatch("out_char", m_tdata, want.out_char);
        if (m_tuser !== want.is_newline)
          report_mismatch("out_is_newline", 16'(m_tuser), 16'(want.is_newline));
        if (want.is_newline) newlines_checked++;
        else chars_checked++;
      end
    end
  end

  // output back-pressure
  initial begin : sink
    m_tready = 1'b0;
    wait (rst === 1'b0);
    forever begin
      @(negedge clk);
      m_tready = 1'b1;
      if (rx_stalls) begin
        repeat ($urandom_range(1, 8)) @(negedge clk);
        m_tready = 1'b0;
        repeat (rx_hold() - 1) @(negedge clk);
      end
    end
  end

  // ---------------- tests ----------------
  task automatic test_defaults();
    send_item(16'h1234, 1'b1);         // empty line: no newline
    send_item(16'h0000, 1'b0);
    send_item(16'hFFFF, 1'b0);
    send_item(lfc_pkg::NEWLINE, 1'b0); // newline code as plain data
    send_item(CH_COMMA, 1'b0);         // not a delimiter in byte mode
    send_item(16'hA5A5, 1'b1);
  endtask

  task automatic test_byte_window();
    wait_idle();
    write_reg(REG_CHAR_OFFSET, 64'd1);
    write_reg(REG_MAX_LENGTH, 64'd2);
    write_reg(REG_SPARE6, {$urandom, $urandom});
    write_reg(REG_SPARE7, {$urandom, $urandom});
    send_item("a", 1'b0);
    send_item("b", 1'b0);
    send_item("c", 1'b0);
    send_item("d", 1'b0);
    send_item(16'h0000, 1'b1);
  endtask

  task automatic test_field_select();
    wait_idle();
    // a count above the slot total means all four slots
    write_all(1'b1, 16'd1, 16'd0, 16'd0, 3'd7, {CH_PIPE, CH_SEMI, CH_COLON, CH_COMMA});
    send_item("x", 1'b0);
    send_item(CH_COMMA, 1'b0);
    send_item("y", 1'b0);
    send_item(CH_PIPE, 1'b0);
    send_item("z", 1'b0);
    send_item(16'h0000, 1'b1);
    // line too short to reach the chosen field
    send_item("q", 1'b0);
    send_item(16'h0000, 1'b1);
  endtask

  task automatic test_no_delims();
    wait_idle();
    write_reg(REG_DELIM_COUNT, 64'd0);
    write_reg(REG_FIELD_NUMBER, 64'd0);
    send_item("a", 1'b0);
    send_item(CH_COMMA, 1'b0);
    send_item("b", 1'b0);
    send_item(16'hFFFF, 1'b1);
  endtask

  function automatic logic [CW-1:0] pick_count(int top);
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return CW'($urandom_range(0, top));
    if (r < 80) return '0;
    if (r < 90) return CNT_TOP;
    return CW'($urandom);
  endfunction

  function automatic logic [CW-1:0] pick_delim();
    case ($urandom_range(0, 6))
      0: return CH_COMMA;
      1: return CH_COLON;
      2: return CH_SPACE;
      3: return CH_TAB;
      4: return 16'hFFFF;
      5: return 16'h0000;
      default: return CW'($urandom);
    endcase
  endfunction

  function automatic logic [CW-1:0] pick_char();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return cut_delims[16*$urandom_range(0, 3) +: 16];
    if (r == 3) return ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
    if (r < 6) return CW'($urandom);
    return CW'("a" + $urandom_range(0, 25));
  endfunction

  task automatic test_random_traffic();
    int phase_items;
    int len;
    for (int phase = 0; phase < 12; phase++) begin
      wait_idle();
      tx_gaps = (phase % 4 != 0);
      rx_stalls = (phase % 4 != 0) && (phase % 3 != 2);
      if (phase == 1)
        write_all(1'b1, CNT_TOP, CNT_TOP, CNT_TOP, 3'd4, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
      else if (phase == 2)
        write_all(1'b0, 16'd0, 16'd0, 16'd0, 3'd0, 64'd0, 1'b1);
      else
        write_all(($urandom_range(0, 3) != 0), pick_count(3), pick_count(3), pick_count(4),
                  3'($urandom_range(0, 7)),
                  {pick_delim(), pick_delim(), pick_delim(), pick_delim()},
                  ($urandom_range(0, 1) != 0));
      phase_items = 0;
      while (phase_items < 110) begin
        len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 12);
        for (int k = 0; k < len; k++) send_item(pick_char(), 1'b0);
        send_item(CW'($urandom), 1'b1);
        phase_items += len + 1;
        if (phase % 2 == 1 && phase_items > 50 && phase_items <= 50 + len + 1)
          wait_idle();
      end
    end
    tx_gaps = 1'b0;
    rx_stalls = 1'b0;
  endtask

  task automatic test_window_no_wrap();
    wait_idle();
    // offset + length goes past 16 bits; a wrapped sum would pass nothing
    write_all(1'b0, 16'd0, 16'd2, CNT_TOP, 3'd1, 64'(CH_COMMA));
    send_item("v", 1'b0);
    send_item("w", 1'b0);
    send_item("x", 1'b0);
    send_item("y", 1'b0);
    send_item("z", 1'b0);
    send_item(16'h0000, 1'b1);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cut_field_mode = 1'b0;
    cut_field_number = '0;
    cut_char_offset = '0;
    cut_max_length = '0;
    cut_delim_count = 3'd1;
    cut_delims = 64'(CH_COMMA);
    clear_line();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_defaults();
    test_byte_window();
    test_field_select();
    test_no_delims();
    test_random_traffic();
    test_window_no_wrap();

    wait_idle();
    repeat (10) @(posedge clk);
    if (pending_out.size() != 0) report_mismatch("results never arrived", '0, '0);
    $display("covered: %0d items sent, %0d register writes", items_sent, reg_writes);
    $display("checked: %0d characters, %0d line newlines, %0d errors",
             chars_checked, newlines_checked, errors);
    if (errors == 0) begin
      $display("line_field_cut_filter: match");
    end else begin
      $display("line_field_cut_filter: mismatch");
    end
    $finish;
  end

endmodule

`default_nettype wire
